>>> sv/cgs_pkg.sv
// Shared types, constants and register codes for the conveyor grade sorter.
package cgs_pkg;

    localparam int RING_DEPTH_DEF   = 32;
    localparam int CAMERA_SLOTS_DEF = 4;
    localparam int STATIONS_DEF     = 5;

    localparam logic [7:0] PUSHED_MARK = 8'h41;
    localparam logic [7:0] GRADE_BASE  = 8'h30;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALVE_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_CMD    = 3'd4;

    localparam logic [3:0]  DEBOUNCE_RST   = 4'd3;
    localparam logic [15:0] CAM_DELAY_RST  = 16'd110;
    localparam logic [15:0] PUSH_DELAY_RST = 16'd30;
    localparam logic [15:0] VALVE_HOLD_RST = 16'd20;
    localparam logic [7:0]  CAM_CMD_RST    = 8'd54;

    typedef struct packed {
        logic [5:0] sensor_levels;
        logic       rx_valid;
        logic [7:0] rx_grade;
    } in_item_t;

    typedef struct packed {
        logic [4:0] valve_drive;
        logic       camera_send;
        logic [7:0] camera_byte;
        logic       skip_exhausted;
    } out_item_t;

endpackage

>>> sv/cgs_debounce.sv
// Sensor debounce and pass-event detection, one lane per sensor.
module cgs_debounce #(
    parameter int SENSORS = cgs_pkg::STATIONS_DEF + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [SENSORS-1:0] samples,
    input  logic [3:0]         debounce_samples,
    output logic [SENSORS-1:0] pass
);

    logic [3:0]         count_reg [SENSORS];
    logic [3:0]         count_next [SENSORS];
    logic [SENSORS-1:0] level_reg, level_next;
    logic [SENSORS-1:0] seen_reg, seen_next;
    logic [3:0]         need;

    assign need = (debounce_samples == 4'd0) ? 4'd1 : debounce_samples;

    always_comb
    begin
        logic [3:0] c;
        c = 4'd0;
        level_next = level_reg;
        seen_next  = seen_reg;
        pass       = '0;
        for (int k = 0; k < SENSORS; k++)
        begin
            count_next[k] = 4'd0;
            if (samples[k] != level_reg[k])
            begin
                c = (count_reg[k] < 4'd15) ? count_reg[k] + 4'd1 : count_reg[k];
                count_next[k] = c;
                if (c >= need)
                begin
                    level_next[k] = samples[k];
                    count_next[k] = 4'd0;
                    if (samples[k])
                    begin
                        seen_next[k] = 1'b1;
                    end
                    else if (seen_reg[k])
                    begin
                        seen_next[k] = 1'b0;
                        pass[k]      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            seen_reg  <= '0;
            for (int k = 0; k < SENSORS; k++)
            begin
                count_reg[k] <= 4'd0;
            end
        end
        else if (step)
        begin
            level_reg <= level_next;
            seen_reg  <= seen_next;
            for (int k = 0; k < SENSORS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

endmodule

>>> sv/cgs_camera.sv
// Round-robin camera delay timers.
module cgs_camera #(
    parameter int CAMERA_SLOTS = cgs_pkg::CAMERA_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        arm,
    input  logic [15:0] camera_delay,
    output logic        send
);

    localparam int SLOT_W = (CAMERA_SLOTS > 1) ? $clog2(CAMERA_SLOTS) : 1;

    logic [CAMERA_SLOTS-1:0] armed_reg, armed_next;
    logic [15:0]             timer_reg [CAMERA_SLOTS];
    logic [15:0]             timer_next [CAMERA_SLOTS];
    logic [SLOT_W-1:0]       slot_reg, slot_next;

    always_comb
    begin
        logic [15:0] t;
        t          = 16'd0;
        armed_next = armed_reg;
        slot_next  = slot_reg;
        send       = 1'b0;
        if (arm)
        begin
            armed_next[slot_reg] = 1'b1;
            slot_next = (slot_reg == SLOT_W'(CAMERA_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
        end
        for (int s = 0; s < CAMERA_SLOTS; s++)
        begin
            timer_next[s] = timer_reg[s];
            if (armed_next[s])
            begin
                t = timer_reg[s] + 16'd1;
                timer_next[s] = t;
                if (t >= camera_delay)
                begin
                    armed_next[s] = 1'b0;
                    timer_next[s] = 16'd0;
                    send          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
            slot_reg  <= '0;
            for (int s = 0; s < CAMERA_SLOTS; s++)
            begin
                timer_reg[s] <= 16'd0;
            end
        end
        else if (step)
        begin
            armed_reg <= armed_next;
            slot_reg  <= slot_next;
            for (int s = 0; s < CAMERA_SLOTS; s++)
            begin
                timer_reg[s] <= timer_next[s];
            end
        end
    end

endmodule

>>> sv/cgs_ring.sv
// Grade ring memory: one write port, one registered read port, valid bits for reset-to-zero.
module cgs_ring #(
    parameter int RING_DEPTH = cgs_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [$clog2(RING_DEPTH)-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [$clog2(RING_DEPTH)-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0]            mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] valid_reg;
    logic [7:0]            rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

endmodule

>>> sv/conveyor_grade_sorter_control_unit.sv
// Conveyor grade sorter control: tick sequencer over debounce, camera timers and grade ring.
// Sequence: after accept, each station steps S_STN then S_TIMER, with S_READ and S_CHECK
// in between for each ring entry read on a pass; S_DONE then loads the result register.
// A full skip walk reads RING_DEPTH entries at its station.
// Throughput: one tick at a time; the next beat is taken the cycle the result shows, or later
// while a stalled result holds the sequencer. Reset (rst_n low, async) clears all sensor,
// timer and slot state, empties the ring to zero through per-entry valid bits, loads defaults.
module conveyor_grade_sorter_control_unit #(
    parameter int RING_DEPTH   = cgs_pkg::RING_DEPTH_DEF,
    parameter int CAMERA_SLOTS = cgs_pkg::CAMERA_SLOTS_DEF,
    parameter int STATIONS     = cgs_pkg::STATIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cgs_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cgs_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SENSORS = STATIONS + 1;
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int STN_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STN   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_TIMER = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [RING_AW-1:0] next_slot(input logic [RING_AW-1:0] s);
        return (s >= RING_AW'(RING_DEPTH - 1)) ? RING_AW'(1) : s + 1'b1;
    endfunction

    // configuration registers
    logic [3:0]  debounce_reg;
    logic [15:0] cam_delay_reg;
    logic [15:0] push_delay_reg;
    logic [15:0] valve_hold_reg;
    logic [7:0]  cam_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= cgs_pkg::DEBOUNCE_RST;
            cam_delay_reg  <= cgs_pkg::CAM_DELAY_RST;
            push_delay_reg <= cgs_pkg::PUSH_DELAY_RST;
            valve_hold_reg <= cgs_pkg::VALVE_HOLD_RST;
            cam_cmd_reg    <= cgs_pkg::CAM_CMD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cgs_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data[3:0];
                cgs_pkg::REG_CAM_DELAY:  cam_delay_reg  <= cfg_data;
                cgs_pkg::REG_PUSH_DELAY: push_delay_reg <= cfg_data;
                cgs_pkg::REG_VALVE_HOLD: valve_hold_reg <= cfg_data;
                cgs_pkg::REG_CAM_CMD:    cam_cmd_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic [2:0] state_reg;
    logic       accept;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // debounce: stations past the sensor field see a constant low
    logic [SENSORS-1:0] samples;
    logic [SENSORS-1:0] pass;
    always_comb
    begin
        samples = '0;
        for (int k = 0; k < SENSORS; k++)
        begin
            if (k < 6)
            begin
                samples[k] = in_data.sensor_levels[k];
            end
        end
    end

    cgs_debounce #(.SENSORS(SENSORS)) u_debounce (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (accept),
        .samples          (samples),
        .debounce_samples (debounce_reg),
        .pass             (pass)
    );

    logic cam_send;
    cgs_camera #(.CAMERA_SLOTS(CAMERA_SLOTS)) u_camera (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .arm          (pass[0]),
        .camera_delay (cam_delay_reg),
        .send         (cam_send)
    );

    // per-tick and per-station state
    logic [SENSORS-1:0] pass_reg;
    logic               send_reg;
    logic               exh_reg;
    logic [4:0]         valves_reg;
    logic [STN_W-1:0]   stn_reg;
    logic [RING_AW-1:0] walk_slot_reg;
    logic [RING_AW-1:0] walked_reg;
    logic [RING_AW-1:0] wr_slot_reg;
    logic [RING_AW-1:0] read_slot_reg [STATIONS];
    logic [15:0]        push_reg [STATIONS];
    logic [15:0]        hold_reg [STATIONS];
    logic               out_valid_reg;
    cgs_pkg::out_item_t out_data_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ring ports
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [7:0]         ring_wdata;
    logic [7:0]         ring_rdata;

    cgs_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (state_reg == S_READ),
        .raddr (walk_slot_reg),
        .rdata (ring_rdata)
    );

    // timer step for the current station
    logic [15:0] pt_cur, pt_inc, pt_new, h_start, h_inc, h_new;
    logic        fire;
    always_comb
    begin
        pt_cur  = push_reg[stn_reg];
        pt_inc  = pt_cur + 16'd1;
        fire    = (pt_cur != 16'd0) && (pt_inc >= push_delay_reg);
        pt_new  = (pt_cur == 16'd0 || fire) ? 16'd0 : pt_inc;
        h_start = fire ? 16'd1 : hold_reg[stn_reg];
        h_inc   = h_start + 16'd1;
        h_new   = (h_start == 16'd0 || h_inc >= valve_hold_reg) ? 16'd0 : h_inc;
    end

    // ring write: host grade at accept with rx_valid, pushed mark when a push fires
    always_comb
    begin
        ring_we    = 1'b0;
        ring_waddr = wr_slot_reg;
        ring_wdata = in_data.rx_grade;
        if (accept && in_data.rx_valid)
        begin
            ring_we = 1'b1;
        end
        else if (state_reg == S_TIMER && fire)
        begin
            ring_we    = 1'b1;
            ring_waddr = read_slot_reg[stn_reg];
            ring_wdata = cgs_pkg::PUSHED_MARK;
        end
    end

    // walk decision
    logic is_mark, skip_on;
    assign is_mark = (ring_rdata == cgs_pkg::PUSHED_MARK);
    assign skip_on = (stn_reg != '0) && is_mark && (walked_reg != RING_AW'(RING_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            wr_slot_reg   <= RING_AW'(1);
            stn_reg       <= '0;
            pass_reg      <= '0;
            send_reg      <= 1'b0;
            exh_reg       <= 1'b0;
            valves_reg    <= '0;
            walk_slot_reg <= '0;
            walked_reg    <= '0;
            for (int n = 0; n < STATIONS; n++)
            begin
                read_slot_reg[n] <= '0;
                push_reg[n]      <= 16'd0;
                hold_reg[n]      <= 16'd0;
            end
        end
        else
        begin
            // the last state loads the result register itself
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_data.rx_valid)
                        begin
                            wr_slot_reg <= next_slot(wr_slot_reg);
                        end
                        pass_reg   <= pass;
                        send_reg   <= cam_send;
                        exh_reg    <= 1'b0;
                        valves_reg <= '0;
                        stn_reg    <= '0;
                        state_reg  <= S_STN;
                    end
                end
                S_STN:
                begin
                    walk_slot_reg <= next_slot(read_slot_reg[stn_reg]);
                    walked_reg    <= '0;
                    state_reg     <= pass_reg[32'(stn_reg) + 1] ? S_READ : S_TIMER;
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (skip_on)
                    begin
                        walk_slot_reg <= next_slot(walk_slot_reg);
                        walked_reg    <= walked_reg + 1'b1;
                        state_reg     <= S_READ;
                    end
                    else
                    begin
                        if (stn_reg != '0 && is_mark)
                        begin
                            exh_reg <= 1'b1;
                        end
                        read_slot_reg[stn_reg] <= walk_slot_reg;
                        if (ring_rdata == 8'(cgs_pkg::GRADE_BASE + 8'(stn_reg)))
                        begin
                            push_reg[stn_reg] <= 16'd1;
                        end
                        state_reg <= S_TIMER;
                    end
                end
                S_TIMER:
                begin
                    push_reg[stn_reg] <= pt_new;
                    hold_reg[stn_reg] <= h_new;
                    if (h_new != 16'd0 && 32'(stn_reg) < 32'd5)
                    begin
                        valves_reg <= valves_reg | (5'd1 << stn_reg);
                    end
                    if (stn_reg == STN_W'(STATIONS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        stn_reg   <= stn_reg + 1'b1;
                        state_reg <= S_STN;
                    end
                end
                S_DONE:
                begin
                    // result register free or emptying this cycle
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg.valve_drive    <= valves_reg;
                        out_data_reg.camera_send    <= send_reg;
                        out_data_reg.camera_byte    <= send_reg ? cam_cmd_reg : 8'd0;
                        out_data_reg.skip_exhausted <= exh_reg;
                        out_valid_reg               <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/cgs_checker.sv
// Port-level checker for the sorter control unit, with its bind.
module cgs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input cgs_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a beat");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.camera_send |-> out_data.camera_byte == 8'd0)
        else $error("camera byte set without a send");

endmodule

bind conveyor_grade_sorter_control_unit cgs_checker u_cgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
